[hw/rtl/ipm_pkg.sv]
// Shared types, codes and constants of the ICMP probe reply matcher.
package ipm_pkg;

  // Default largest packet length that is counted; longer packets are clipped.
  localparam int MAX_PACKET_BYTES_DEF = 1024;

  // Bytes in one header length unit.
  localparam int WORD_BYTES = 4;

  // Widths of the configuration request port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OWN_ID             = 3'd0,
    CFG_EXPECTED_SEQ       = 3'd1,
    CFG_SEND_TICK          = 3'd2,
    CFG_ECHO_REPLY_TYPE    = 3'd3,
    CFG_TIME_EXCEEDED_TYPE = 3'd4,
    CFG_TARGET_ADDRESS     = 3'd5
  } cfg_reg_t;

  // Verdict codes.
  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_TOO_SHORT       = 3'd1,
    ST_OTHER_TYPE      = 3'd2,
    ST_MISMATCH        = 3'd3,
    ST_INNER_TRUNCATED = 3'd4
  } status_t;

  // Reset values of the type code registers.
  localparam logic [7:0] ECHO_REPLY_TYPE_RST    = 8'd0;
  localparam logic [7:0] TIME_EXCEEDED_TYPE_RST = 8'd11;

  // Configuration registers as seen by the decoder.
  typedef struct packed {
    logic [15:0] own_id;
    logic [15:0] expected_seq;
    logic [31:0] send_tick;
    logic [7:0]  echo_reply_type;
    logic [7:0]  time_exceeded_type;
    logic [31:0] target_address;
  } ipm_cfg_t;

  // One verdict for one packet.
  typedef struct packed {
    logic        accepted;
    status_t     status;
    logic        reply_kind;
    logic [31:0] source_address;
    logic [31:0] round_trip;
    logic        reached_target;
  } ipm_result_t;

endpackage

[hw/rtl/ipm_decode.sv]
// Per-packet byte decoder: header field capture and the verdict on the final byte.
module ipm_decode #(
  parameter int MAX_PACKET_BYTES = ipm_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipm_pkg::ipm_cfg_t    cfg,
  input  logic                 step,
  input  logic [7:0]           pkt_byte,
  input  logic                 pkt_last,
  input  logic [31:0]          tick,
  output ipm_pkg::ipm_result_t result
);

  localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);
  // Offsets compared against header positions reach a little over 128.
  localparam int CMP_W = (OFF_W > 9) ? OFF_W : 9;
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_PACKET_BYTES);

  logic [OFF_W-1:0] off_r, off_nxt;
  logic [3:0]       ohw_r, ohw_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [3:0]       ihw_r, ihw_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [1:0]       seen_r, seen_nxt;

  logic [CMP_W-1:0] p;
  logic [CMP_W-1:0] h;
  logic [CMP_W-1:0] inner_base;
  logic [CMP_W-1:0] len;
  logic             echo_m;
  logic             te_m;

  // Places a byte into id or sequence when it sits at base + 4 .. base + 7.
  function automatic logic [31:0] take_id_seq(input logic [CMP_W-1:0] pos,
                                               input logic [CMP_W-1:0] base,
                                               input logic [7:0]       b,
                                               input logic [31:0]      seq_id);
    logic [31:0] r;
    r = seq_id;
    if (pos == base + CMP_W'(4)) r[7:0]   = b;
    if (pos == base + CMP_W'(5)) r[15:8]  = b;
    if (pos == base + CMP_W'(6)) r[23:16] = b;
    if (pos == base + CMP_W'(7)) r[31:24] = b;
    return r;
  endfunction

  always_comb begin
    off_nxt  = off_r;
    ohw_nxt  = ohw_r;
    type_nxt = type_r;
    src_nxt  = src_r;
    ihw_nxt  = ihw_r;
    id_nxt   = id_r;
    seq_nxt  = seq_r;
    seen_nxt = seen_r;
    p        = CMP_W'(off_r);
    h        = '0;
    inner_base = '0;

    if (step && (off_r < MAX_OFF)) begin
      if (off_r == '0) ohw_nxt = pkt_byte[3:0];
      h = CMP_W'({ohw_nxt, 2'b00});
      if ((p >= CMP_W'(12)) && (p <= CMP_W'(15))) begin
        src_nxt[{p[1:0], 3'b000} +: 8] = src_r[{p[1:0], 3'b000} +: 8] | pkt_byte;
      end
      if (p == h) begin
        type_nxt    = pkt_byte;
        seen_nxt[0] = 1'b1;
      end
      if (seen_nxt[0]) begin
        if (type_nxt == cfg.echo_reply_type) begin
          {seq_nxt, id_nxt} = take_id_seq(p, h, pkt_byte, {seq_r, id_r});
        end else if (type_nxt == cfg.time_exceeded_type) begin
          if (p == h + CMP_W'(8)) begin
            ihw_nxt     = pkt_byte[3:0];
            seen_nxt[1] = 1'b1;
          end
          inner_base = h + CMP_W'(8) + CMP_W'({ihw_nxt, 2'b00});
          if (seen_nxt[1]) begin
            {seq_nxt, id_nxt} = take_id_seq(p, inner_base, pkt_byte, {seq_r, id_r});
          end
        end
      end
      off_nxt = off_r + OFF_W'(1);
    end

    // Verdict, formed from the state as it stands after this byte.
    len    = CMP_W'(off_nxt);
    echo_m = (type_nxt == cfg.echo_reply_type);
    te_m   = (type_nxt == cfg.time_exceeded_type);
    result = '0;
    result.source_address = src_nxt;
    if (len < CMP_W'({ohw_nxt, 2'b00}) + CMP_W'(8)) begin
      result.status = ipm_pkg::ST_TOO_SHORT;
    end else if (echo_m) begin
      result.status = ipm_pkg::ST_OK;
    end else if (te_m) begin
      result.reply_kind = 1'b1;
      if (len < CMP_W'({ohw_nxt, 2'b00}) + CMP_W'(16) + CMP_W'({ihw_nxt, 2'b00})) begin
        result.status = ipm_pkg::ST_INNER_TRUNCATED;
      end else begin
        result.status = ipm_pkg::ST_OK;
      end
    end else begin
      result.status = ipm_pkg::ST_OTHER_TYPE;
    end
    if ((result.status == ipm_pkg::ST_OK) &&
        ((id_nxt != cfg.own_id) || (seq_nxt != cfg.expected_seq))) begin
      result.status = ipm_pkg::ST_MISMATCH;
    end
    if (result.status == ipm_pkg::ST_OK) begin
      result.accepted       = 1'b1;
      result.round_trip     = tick - cfg.send_tick;
      result.reached_target = (src_nxt == cfg.target_address);
    end

    // The final byte closes the packet and clears all capture state.
    if (step && pkt_last) begin
      off_nxt  = '0;
      ohw_nxt  = '0;
      type_nxt = '0;
      src_nxt  = '0;
      ihw_nxt  = '0;
      id_nxt   = '0;
      seq_nxt  = '0;
      seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      ohw_r  <= '0;
      type_r <= '0;
      src_r  <= '0;
      ihw_r  <= '0;
      id_r   <= '0;
      seq_r  <= '0;
      seen_r <= '0;
    end else begin
      off_r  <= off_nxt;
      ohw_r  <= ohw_nxt;
      type_r <= type_nxt;
      src_r  <= src_nxt;
      ihw_r  <= ihw_nxt;
      id_r   <= id_nxt;
      seq_r  <= seq_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

[hw/rtl/icmp_probe_reply_matcher_unit.sv]
// Top level of the ICMP probe reply matcher: stream ports, configuration and output register.
//
// The block reads a received IPv4 packet one byte per request on the in_ stream,
// with in_tlast on the final byte. It captures the outer source address and the
// ICMP type, then the identifier and sequence of an echo reply, or those of the
// quoted inner ICMP header of a time-exceeded message. For each packet it gives
// one verdict request on the out_ stream, with the round-trip ticks on success.
// Bytes that are not final produce no output request.
// Each accepted byte is held in an input register, decoded by the following
// logic, and for a final byte the verdict lands in the output register, which
// drives out_tvalid. The block takes one byte per cycle for as long as the
// output is free; this rate is set by the single decode step between the
// input and output registers.
// When the receiver stalls with a verdict waiting, further non-final bytes are
// still taken; a second final byte waits in the input register until the
// output register empties, and in_tready drops only in that case.
// Synchronous active-low reset clears the packet state and both handshakes and
// loads the register defaults (time-exceeded type 11, all others 0).
// Configuration requests are always taken; the user, not the block, keeps them to idle.
module icmp_probe_reply_matcher_unit #(
  parameter int MAX_PACKET_BYTES = ipm_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream. tdata: packet_byte [7:0], arrival_tick [39:8]. tlast: last_byte.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ipm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  // Result stream. tdata: accepted [0], status [3:1], source_address [35:4],
  // round_trip [67:36], reached_target [68], zero fill [71:69].
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ipm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tuser: reply_kind [0].
  output logic                            out_tuser,
  // Configuration write port.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ipm_pkg::ipm_cfg_t    cfg_r;
  ipm_pkg::ipm_result_t dec_res;
  ipm_pkg::ipm_result_t out_res_r;

  logic        stg_valid_r, stg_valid_nxt;
  logic [7:0]  stg_byte_r;
  logic        stg_last_r;
  logic [31:0] stg_tick_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_accept;
  logic        out_free;
  logic        advance;

  // Configuration requests are taken at once; the user, not the block, keeps them to idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id             <= '0;
      cfg_r.expected_seq       <= '0;
      cfg_r.send_tick          <= '0;
      cfg_r.echo_reply_type    <= ipm_pkg::ECHO_REPLY_TYPE_RST;
      cfg_r.time_exceeded_type <= ipm_pkg::TIME_EXCEEDED_TYPE_RST;
      cfg_r.target_address     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (ipm_pkg::cfg_reg_t'(cfg_index))
        ipm_pkg::CFG_OWN_ID:             cfg_r.own_id             <= cfg_data[15:0];
        ipm_pkg::CFG_EXPECTED_SEQ:       cfg_r.expected_seq       <= cfg_data[15:0];
        ipm_pkg::CFG_SEND_TICK:          cfg_r.send_tick          <= cfg_data;
        ipm_pkg::CFG_ECHO_REPLY_TYPE:    cfg_r.echo_reply_type    <= cfg_data[7:0];
        ipm_pkg::CFG_TIME_EXCEEDED_TYPE: cfg_r.time_exceeded_type <= cfg_data[7:0];
        ipm_pkg::CFG_TARGET_ADDRESS:     cfg_r.target_address     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A byte leaves the input register every cycle, except a final byte whose
  // verdict would land on a full output register that is not being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = stg_valid_r && (!stg_last_r || out_free);
  assign in_tready = !stg_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_accept) begin
      stg_valid_nxt = 1'b1;
    end else if (advance) begin
      stg_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance && stg_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_byte_r <= in_tdata[7:0];
      stg_tick_r <= in_tdata[39:8];
      stg_last_r <= in_tlast;
    end
    if (advance && stg_last_r) begin
      out_res_r <= dec_res;
    end
  end

  ipm_decode #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step     (advance),
    .pkt_byte (stg_byte_r),
    .pkt_last (stg_last_r),
    .tick     (stg_tick_r),
    .result   (dec_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.reply_kind;
  assign out_tdata  = {3'b000,
                       out_res_r.reached_target,
                       out_res_r.round_trip,
                       out_res_r.source_address,
                       out_res_r.status,
                       out_res_r.accepted};

  // A verdict marked accepted always carries the success code.
  a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.accepted |-> out_res_r.status == ipm_pkg::ST_OK)
    else $error("accepted verdict without success code");

  // Reaching the target is only reported for an accepted verdict.
  a_reach_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.reached_target |-> out_res_r.accepted)
    else $error("target reached on a rejected verdict");

  // Input back-pressure only comes from a final byte held behind a stalled output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> stg_valid_r && stg_last_r && out_valid_r && !out_tready)
    else $error("input stalled without a blocked final byte");

  // A blocked final byte keeps its place until the output drains.
  a_final_held: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && stg_last_r && out_valid_r && !out_tready
    |=> stg_valid_r && stg_last_r && $stable(stg_tick_r))
    else $error("blocked final byte lost");

  // A verdict follows the final byte when the output is free.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && stg_last_r && out_free |=> out_valid_r)
    else $error("final byte gave no verdict");

endmodule
